// File: rtl/core/hfl_pkg.sv
// Shared types, codes and constants for the hex firmware loader receiver.
package hfl_pkg;

   localparam int PAGE_BYTES_DEF = 512;
   localparam logic [11:0] FIRST_PAGE_RESET = 12'd128;
   localparam logic [15:0] FINAL_ADDR = 16'hFE00;

   localparam logic [7:0] ASCII_0 = 8'h30;
   localparam logic [7:0] ASCII_9 = 8'h39;
   localparam logic [7:0] ASCII_A = 8'h41;
   localparam logic [7:0] ASCII_F = 8'h46;
   localparam logic [7:0] ASCII_AT = 8'h40;
   localparam logic [7:0] ASCII_UR = 8'h52;
   localparam logic [7:0] ASCII_LR = 8'h72;
   localparam logic [7:0] ASCII_UQ = 8'h51;
   localparam logic [7:0] ASCII_LQ = 8'h71;
   localparam logic [7:0] ASCII_U = 8'h55;

   localparam logic [2:0] KW_LEN = 3'd6;
   localparam logic [2:0] KW_LAST = 3'd5;
   localparam logic [7:0] KEYWORD [6] = '{8'h55, 8'h70, 8'h6C, 8'h6F, 8'h61, 8'h64};

   localparam logic [2:0] EV_NONE = 3'd0;
   localparam logic [2:0] EV_KEYWORD = 3'd1;
   localparam logic [2:0] EV_ADDRESS = 3'd2;
   localparam logic [2:0] EV_WORD = 3'd3;
   localparam logic [2:0] EV_PAGE = 3'd4;
   localparam logic [2:0] EV_FINAL = 3'd5;
   localparam logic [2:0] EV_RESTORE = 3'd6;
   localparam logic [2:0] EV_QUIT = 3'd7;

   localparam logic CSR_UPDATE_MODE = 1'b0;
   localparam logic CSR_FIRST_PAGE = 1'b1;

   typedef struct packed {
      logic        update_mode;
      logic [11:0] first_page;
   } hfl_cfg_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [15:0] word_value;
      logic [8:0]  byte_offset;
      logic [11:0] page_number;
      logic [7:0]  page_checksum;
   } hfl_result_type;

endpackage

// File: rtl/core/hfl_if.sv
// Valid/ready channel interfaces for received bytes and result transactions.
interface hfl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source(output valid, output rx_byte, input ready);
   modport sink(input valid, input rx_byte, output ready);
endinterface

interface hfl_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_res;
   logic        pass_through;
   logic [15:0] word_value;
   logic [8:0]  byte_offset;
   logic [11:0] page_number;
   logic [7:0]  page_checksum;

   modport source(output valid, output event_res, output pass_through, output word_value,
                  output byte_offset, output page_number, output page_checksum, input ready);
   modport sink(input valid, input event_res, input pass_through, input word_value,
                input byte_offset, input page_number, input page_checksum, output ready);
endinterface

// File: rtl/core/hfl_csr.sv
// APB-style configuration registers: update mode and first page.
module hfl_csr import hfl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output hfl_cfg_type cfg
);

   logic        update_mode_ff;
   logic [11:0] first_page_ff;
   logic        wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         update_mode_ff <= 1'b0;
         first_page_ff <= FIRST_PAGE_RESET;
      end else if (wr_en) begin
         unique case (csr_paddr[2])
            CSR_UPDATE_MODE: update_mode_ff <= csr_pwdata[0];
            CSR_FIRST_PAGE: first_page_ff <= csr_pwdata[11:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         CSR_UPDATE_MODE: csr_prdata = {31'd0, update_mode_ff};
         CSR_FIRST_PAGE: csr_prdata = {20'd0, first_page_ff};
         default: csr_prdata = 32'd0;
      endcase
   end

   assign cfg.update_mode = update_mode_ff;
   assign cfg.first_page = first_page_ff;

endmodule

// File: rtl/core/hfl_keyword.sv
// Keyword matcher for normal mode: tracks position and match-so-far.
module hfl_keyword import hfl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  logic [7:0] rx_byte,
   output logic       seen
);

   logic [2:0] pos_ff, pos_in;
   logic       match_ff, match_in;
   logic [2:0] pos_base, pos_inc;
   logic       match_base, match_new, is_u;

   always_comb begin
      is_u = (rx_byte == ASCII_U);
      pos_base = is_u ? 3'd0 : pos_ff;
      match_base = match_ff;
      if (is_u || pos_ff > KW_LAST) begin
         match_base = 1'b1;
      end
      if (pos_base > KW_LAST) begin
         pos_base = 3'd0;
      end
      match_new = match_base && (rx_byte == KEYWORD[pos_base]);
      pos_inc = pos_base + 3'd1;
      if (pos_inc == KW_LEN) begin
         seen = match_new;
         pos_in = 3'd0;
         match_in = 1'b1;
      end else begin
         seen = 1'b0;
         pos_in = pos_inc;
         match_in = match_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 3'd0;
         match_ff <= 1'b1;
      end else if (advance) begin
         pos_ff <= pos_in;
         match_ff <= match_in;
      end
   end

endmodule

// File: rtl/core/hfl_hex_parser.sv
// Hex upload parser: address load, word assembly, page fill and checksum.
module hfl_hex_parser import hfl_pkg::*; #(
   parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  logic [7:0]     rx_byte,
   input  logic [11:0]    first_page,
   output hfl_result_type result
);

   localparam int FILL_W = $clog2(PAGE_BYTES + 2);
   localparam int PAGE_L = $clog2(PAGE_BYTES);
   localparam int PAGE_SH = 16 + PAGE_L;
   localparam logic [16:0] PAGE_RECIP =
      17'(((64'd1 << PAGE_SH) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES));

   logic              addr_phase_ff, addr_phase_in;
   logic [2:0]        digits_left_ff, digits_left_in;
   logic [15:0]       load_addr_ff, load_addr_in;
   logic [15:0]       word_accum_ff, word_accum_in;
   logic [2:0]        word_left_ff, word_left_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [11:0]       page_ff, page_in;
   logic [7:0]        xor_ff, xor_in;

   logic              is_digit;
   logic [3:0]        digit;
   logic [1:0]        addr_n;
   logic [15:0]       addr_digit;
   logic [32:0]       page_prod;
   logic [11:0]       page_calc;
   logic [2:0]        word_left_dec;
   logic [15:0]       word_done;
   logic [FILL_W-1:0] fill_add;
   logic [7:0]        xor_add;
   logic [15:0]       addr_add;
   logic [15:0]       addr_back;

   always_comb begin
      is_digit = 1'b0;
      digit = 4'd0;
      if (rx_byte >= ASCII_0 && rx_byte <= ASCII_9) begin
         is_digit = 1'b1;
         digit = 4'(rx_byte - ASCII_0);
      end else if (rx_byte >= ASCII_A && rx_byte <= ASCII_F) begin
         is_digit = 1'b1;
         digit = 4'(rx_byte - ASCII_A + 8'd10);
      end
   end

   assign addr_n = (digits_left_ff != 3'd0) ? 2'(digits_left_ff - 3'd1) : 2'd0;
   assign addr_digit = load_addr_ff | (16'(digit) << {addr_n, 2'b00});
   assign page_prod = 33'(addr_digit) * 33'(PAGE_RECIP);
   assign page_calc = 12'(page_prod >> PAGE_SH) + first_page;
   assign word_left_dec = word_left_ff - 3'd1;
   assign word_done = word_accum_ff | 16'(digit);
   assign fill_add = fill_ff + FILL_W'(2);
   assign xor_add = xor_ff ^ word_done[15:8] ^ word_done[7:0];
   assign addr_add = load_addr_ff + 16'd2;
   assign addr_back = addr_add - 16'(PAGE_BYTES);

   always_comb begin
      addr_phase_in = addr_phase_ff;
      digits_left_in = digits_left_ff;
      load_addr_in = load_addr_ff;
      word_accum_in = word_accum_ff;
      word_left_in = word_left_ff;
      fill_in = fill_ff;
      page_in = page_ff;
      xor_in = xor_ff;
      result = '0;
      if (rx_byte == ASCII_AT) begin
         addr_phase_in = 1'b1;
         load_addr_in = 16'd0;
         word_accum_in = 16'd0;
         digits_left_in = 3'd4;
      end else if (rx_byte == ASCII_UR || rx_byte == ASCII_LR) begin
         result.event_res = EV_RESTORE;
      end else if (rx_byte == ASCII_UQ || rx_byte == ASCII_LQ) begin
         result.event_res = EV_QUIT;
      end else if (is_digit) begin
         if (addr_phase_ff) begin
            digits_left_in = 3'(addr_n);
            load_addr_in = addr_digit;
            page_in = page_calc;
            if (addr_n == 2'd0) begin
               addr_phase_in = 1'b0;
               word_left_in = 3'd4;
               fill_in = '0;
               xor_in = 8'd0;
               result.event_res = EV_ADDRESS;
               result.page_number = page_calc;
            end
         end else if (word_left_ff > 3'd1) begin
            word_left_in = word_left_dec;
            word_accum_in = word_accum_ff | (16'(digit) << {word_left_dec[1:0], 2'b00});
         end else begin
            result.event_res = EV_WORD;
            result.word_value = word_done;
            result.byte_offset = 9'(fill_ff);
            result.page_number = page_ff;
            load_addr_in = addr_add;
            word_left_in = 3'd4;
            word_accum_in = 16'd0;
            fill_in = fill_add;
            xor_in = xor_add;
            if (fill_add >= FILL_W'(PAGE_BYTES)) begin
               result.page_checksum = xor_add;
               result.event_res = (addr_back == FINAL_ADDR) ? EV_FINAL : EV_PAGE;
               fill_in = '0;
               xor_in = 8'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_phase_ff <= 1'b0;
         digits_left_ff <= 3'd0;
         load_addr_ff <= 16'd0;
         word_accum_ff <= 16'd0;
         word_left_ff <= 3'd0;
         fill_ff <= '0;
         page_ff <= FIRST_PAGE_RESET;
         xor_ff <= 8'd0;
      end else if (advance) begin
         addr_phase_ff <= addr_phase_in;
         digits_left_ff <= digits_left_in;
         load_addr_ff <= load_addr_in;
         word_accum_ff <= word_accum_in;
         word_left_ff <= word_left_in;
         fill_ff <= fill_in;
         page_ff <= page_in;
         xor_ff <= xor_in;
      end
   end

endmodule

// File: rtl/core/hex_firmware_loader_receiver.sv
// Hex firmware loader receiver: input register, parse logic, result register.
// A byte is held in the input register, then its result in the result register.
// Throughput: one byte per cycle while rsp.ready does not stall; the input and result
// registers part the channels, so one byte can be taken while a finished result waits.
// Reset: synchronous, active high; clears both registers' valid flags, the parser
// and matcher state, and the configuration (update mode off, first page 128).
module hex_firmware_loader_receiver import hfl_pkg::*; #(
   parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   hfl_req_if.sink     req,
   hfl_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   hfl_cfg_type    cfg;
   hfl_result_type hex_result;
   hfl_result_type result_in, result_ff;
   logic           in_valid_ff;
   logic [7:0]     in_byte_ff;
   logic           out_valid_ff;
   logic           pass_in, pass_ff;
   logic           advance;
   logic           kw_seen;

   hfl_csr u_csr (
      .clock(clock),
      .reset(reset),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .cfg(cfg)
   );

   assign advance = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;

   hfl_keyword u_keyword (
      .clock(clock),
      .reset(reset),
      .advance(advance && !cfg.update_mode),
      .rx_byte(in_byte_ff),
      .seen(kw_seen)
   );

   hfl_hex_parser #(.PAGE_BYTES(PAGE_BYTES)) u_hex_parser (
      .clock(clock),
      .reset(reset),
      .advance(advance && cfg.update_mode),
      .rx_byte(in_byte_ff),
      .first_page(cfg.first_page),
      .result(hex_result)
   );

   always_comb begin
      if (cfg.update_mode) begin
         result_in = hex_result;
         pass_in = 1'b0;
      end else begin
         result_in = '0;
         result_in.event_res = kw_seen ? EV_KEYWORD : EV_NONE;
         pass_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.valid && req.ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_byte_ff <= req.rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
         pass_ff <= pass_in;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.event_res = result_ff.event_res;
   assign rsp.pass_through = pass_ff;
   assign rsp.word_value = result_ff.word_value;
   assign rsp.byte_offset = result_ff.byte_offset;
   assign rsp.page_number = result_ff.page_number;
   assign rsp.page_checksum = result_ff.page_checksum;

endmodule

// File: rtl/core/hfl_checker.sv
// Port-level checker for the result channel, bound to the top level.
module hfl_checker import hfl_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_event_res,
   input logic        rsp_pass_through,
   input logic [15:0] rsp_word_value,
   input logic [8:0]  rsp_byte_offset,
   input logic [11:0] rsp_page_number,
   input logic [7:0]  rsp_page_checksum
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_res)
         && $stable(rsp_word_value) && $stable(rsp_page_checksum))
      else $error("result changed while stalled");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_pass: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pass_through == (rsp_event_res == EV_NONE && rsp_pass_through
         || rsp_event_res == EV_KEYWORD)))
      else $error("pass-through and event disagree");

   a_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res == EV_NONE || rsp_event_res == EV_KEYWORD
         || rsp_event_res == EV_RESTORE || rsp_event_res == EV_QUIT)
      |-> rsp_word_value == 16'd0 && rsp_page_number == 12'd0 && rsp_page_checksum == 8'd0)
      else $error("payload set on a non-data event");

   a_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_byte_offset[0]
         && (rsp_event_res != EV_WORD || rsp_page_checksum == 8'd0))
      else $error("bad word offset or checksum");

endmodule

bind hex_firmware_loader_receiver hfl_checker u_hfl_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp.valid),
   .rsp_ready(rsp.ready),
   .rsp_event_res(rsp.event_res),
   .rsp_pass_through(rsp.pass_through),
   .rsp_word_value(rsp.word_value),
   .rsp_byte_offset(rsp.byte_offset),
   .rsp_page_number(rsp.page_number),
   .rsp_page_checksum(rsp.page_checksum)
);

// File: tb/tb_top.sv
// Self-checking testbench for the hex firmware loader receiver: byte stream in, events out.
`timescale 1ns / 100ps

module tb_top;
   import hfl_pkg::*;

   typedef struct packed {
      logic [2:0]  event_res;
      logic        pass_through;
      logic [15:0] word_value;
      logic [8:0]  byte_offset;
      logic [11:0] page_number;
      logic [7:0]  page_checksum;
   } loader_rsp_type;

   typedef struct packed {
      bit             pin;
      loader_rsp_type want;
   } pin_entry_type;

   typedef enum logic {ROW_BYTE, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type   kind;
      logic [2:0]     addr;
      logic [31:0]    data;
      bit             pin;
      loader_rsp_type want;
   } plan_row_type;

   typedef logic [15:0] field_vec_type [6];

   localparam logic [2:0] REG_MODE_ADDR = {CSR_UPDATE_MODE, 2'b00};
   localparam logic [2:0] REG_PAGE_ADDR = {CSR_FIRST_PAGE, 2'b00};
   localparam int PLAN_ROWS = 24;
   localparam int WORDS_PER_PAGE = PAGE_BYTES_DEF / 2;

   localparam loader_rsp_type NONE_PASS = '{EV_NONE, 1'b1, 16'h0, 9'd0, 12'd0, 8'h0};
   localparam loader_rsp_type NONE_UPD = '{EV_NONE, 1'b0, 16'h0, 9'd0, 12'd0, 8'h0};
   localparam loader_rsp_type KW_SEEN = '{EV_KEYWORD, 1'b1, 16'h0, 9'd0, 12'd0, 8'h0};
   localparam loader_rsp_type EARLY_WORD = '{EV_WORD, 1'b0, 16'h0003, 9'd0, 12'd128, 8'h0};
   localparam loader_rsp_type RESTORE_REQ = '{EV_RESTORE, 1'b0, 16'h0, 9'd0, 12'd0, 8'h0};
   localparam loader_rsp_type QUIT_REQ = '{EV_QUIT, 1'b0, 16'h0, 9'd0, 12'd0, 8'h0};
   localparam loader_rsp_type ADDR_TOP = '{EV_ADDRESS, 1'b0, 16'h0, 9'd0, 12'd127, 8'h0};
   localparam loader_rsp_type WORD_ONES = '{EV_WORD, 1'b0, 16'hFFFF, 9'd0, 12'd127, 8'h0};
   localparam logic [7:0] CMD_BYTES [4] = '{ASCII_UR, ASCII_LR, ASCII_UQ, ASCII_LQ};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = 3'd0;
   logic [31:0] csr_pwdata = 32'd0;
   wire [31:0] csr_prdata;
   wire csr_pready;

   hfl_req_if req_ch ();
   hfl_rsp_if rsp_ch ();

   hex_firmware_loader_receiver dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // shadow of the block's configuration, keyword matcher and parser state
   logic m_update_mode = 1'b0;
   logic [11:0] m_first_page = FIRST_PAGE_RESET;
   logic [2:0] kw_pos = 3'd0;
   logic [7:0] kw_seen [6] = '{default: 8'h00};
   logic addr_phase = 1'b0;
   logic [2:0] addr_digits_left = 3'd0;
   logic [15:0] load_addr = 16'h0;
   logic [15:0] word_acc = 16'h0;
   logic [2:0] word_digits_left = 3'd0;
   logic [9:0] fill = 10'd0;
   logic [11:0] cur_page = FIRST_PAGE_RESET;
   logic [7:0] page_xor = 8'h0;

   loader_rsp_type expected_q [$];
   pin_entry_type pin_q [$];
   loader_rsp_type predicted, got_now, want_now;
   pin_entry_type pinned_now;
   field_vec_type got_f, want_f;
   string field_names [6] = '{"event_res", "pass_through", "word_value", "byte_offset",
                              "page_number", "page_checksum"};

   int errors = 0;
   int sent_count = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   logic hold_off = 1'b0;

   plan_row_type plan [PLAN_ROWS] = '{
      '{ROW_BYTE, 3'd0, 32'h55, 1'b1, NONE_PASS},
      '{ROW_BYTE, 3'd0, 32'h70, 1'b0, NONE_PASS},
      '{ROW_BYTE, 3'd0, 32'h6C, 1'b0, NONE_PASS},
      '{ROW_BYTE, 3'd0, 32'h6F, 1'b0, NONE_PASS},
      '{ROW_BYTE, 3'd0, 32'h61, 1'b0, NONE_PASS},
      '{ROW_BYTE, 3'd0, 32'h64, 1'b1, KW_SEEN},
      '{ROW_BYTE, 3'd0, 32'h00, 1'b1, NONE_PASS},
      '{ROW_CSR, REG_PAGE_ADDR, 32'd0, 1'b0, NONE_UPD},
      '{ROW_CSR, REG_MODE_ADDR, 32'd1, 1'b0, NONE_UPD},
      '{ROW_BYTE, 3'd0, 32'h33, 1'b1, EARLY_WORD},
      '{ROW_BYTE, 3'd0, 32'(ASCII_UR), 1'b1, RESTORE_REQ},
      '{ROW_BYTE, 3'd0, 32'(ASCII_LR), 1'b1, RESTORE_REQ},
      '{ROW_BYTE, 3'd0, 32'(ASCII_UQ), 1'b1, QUIT_REQ},
      '{ROW_BYTE, 3'd0, 32'(ASCII_LQ), 1'b1, QUIT_REQ},
      '{ROW_BYTE, 3'd0, 32'hFF, 1'b1, NONE_UPD},
      '{ROW_BYTE, 3'd0, 32'(ASCII_AT), 1'b1, NONE_UPD},
      '{ROW_BYTE, 3'd0, 32'(ASCII_F), 1'b0, NONE_UPD},
      '{ROW_BYTE, 3'd0, 32'h45, 1'b0, NONE_UPD},
      '{ROW_BYTE, 3'd0, 32'(ASCII_0), 1'b0, NONE_UPD},
      '{ROW_BYTE, 3'd0, 32'(ASCII_0), 1'b1, ADDR_TOP},
      '{ROW_BYTE, 3'd0, 32'(ASCII_F), 1'b0, NONE_UPD},
      '{ROW_BYTE, 3'd0, 32'(ASCII_F), 1'b0, NONE_UPD},
      '{ROW_BYTE, 3'd0, 32'(ASCII_F), 1'b0, NONE_UPD},
      '{ROW_BYTE, 3'd0, 32'(ASCII_F), 1'b1, WORD_ONES}
   };

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #3_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic loader_rsp_type predict_byte(input logic [7:0] b);
      loader_rsp_type r;
      logic is_digit;
      logic [3:0] nib;
      logic [1:0] n;
      logic match;
      r = '0;
      is_digit = (b >= ASCII_0 && b <= ASCII_9) || (b >= ASCII_A && b <= ASCII_F);
      nib = (b <= ASCII_9) ? 4'(b - ASCII_0) : 4'(b - ASCII_A + 8'd10);
      if (!m_update_mode) begin
         r.pass_through = 1'b1;
         if (b == ASCII_U) begin
            kw_pos = 3'd0;
            foreach (kw_seen[i]) kw_seen[i] = 8'h00;
         end
         if (kw_pos > KW_LAST) kw_pos = 3'd0;
         kw_seen[kw_pos] = b;
         kw_pos++;
         if (kw_pos == KW_LEN) begin
            match = 1'b1;
            foreach (kw_seen[i]) if (kw_seen[i] != KEYWORD[i]) match = 1'b0;
            kw_pos = 3'd0;
            foreach (kw_seen[i]) kw_seen[i] = 8'h00;
            if (match) r.event_res = EV_KEYWORD;
         end
      end else if (b == ASCII_AT) begin
         addr_phase = 1'b1;
         load_addr = 16'h0;
         word_acc = 16'h0;
         addr_digits_left = 3'd4;
      end else if (b == ASCII_UR || b == ASCII_LR) begin
         r.event_res = EV_RESTORE;
      end else if (b == ASCII_UQ || b == ASCII_LQ) begin
         r.event_res = EV_QUIT;
      end else if (is_digit) begin
         if (addr_phase) begin
            n = (addr_digits_left > 3'd0) ? 2'(addr_digits_left - 3'd1) : 2'd0;
            addr_digits_left = 3'(n);
            load_addr = load_addr | (16'(nib) << (4 * n));
            cur_page = 12'(int'(load_addr) / PAGE_BYTES_DEF + int'(m_first_page));
            if (n == 2'd0) begin
               addr_phase = 1'b0;
               word_digits_left = 3'd4;
               fill = 10'd0;
               page_xor = 8'h0;
               r.event_res = EV_ADDRESS;
               r.page_number = cur_page;
            end
         end else if (word_digits_left > 3'd1) begin
            word_digits_left = word_digits_left - 3'd1;
            word_acc = word_acc | (16'(nib) << (4 * word_digits_left));
         end else begin
            word_acc = word_acc | 16'(nib);
            r.word_value = word_acc;
            r.byte_offset = fill[8:0];
            page_xor = page_xor ^ word_acc[15:8] ^ word_acc[7:0];
            load_addr = load_addr + 16'd2;
            fill = fill + 10'd2;
            word_digits_left = 3'd4;
            word_acc = 16'h0;
            r.page_number = cur_page;
            r.event_res = EV_WORD;
            if (int'(fill) >= PAGE_BYTES_DEF) begin
               r.page_checksum = page_xor;
               r.event_res = (16'(load_addr - 16'(PAGE_BYTES_DEF)) == FINAL_ADDR) ?
                             EV_FINAL : EV_PAGE;
               fill = 10'd0;
               page_xor = 8'h0;
            end
         end
      end
      return r;
   endfunction

   function automatic field_vec_type fields_of(input loader_rsp_type r);
      return '{16'(r.event_res), 16'(r.pass_through), r.word_value, 16'(r.byte_offset),
               16'(r.page_number), 16'(r.page_checksum)};
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      return (nib < 4'd10) ? ASCII_0 + 8'(nib) : ASCII_A + 8'(nib) - 8'd10;
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got_v,
                                  input logic [15:0] want_v);
      if (errors < 100)
         $display("%0t ns: mismatch on %s, got %h, want %h", $time, what, got_v, want_v);
      errors++;
   endtask

   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         predicted = predict_byte(req_ch.rx_byte);
         pinned_now = pin_q.pop_front();
         expected_q.push_back(pinned_now.pin ? pinned_now.want : predicted);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got_now = '{rsp_ch.event_res, rsp_ch.pass_through, rsp_ch.word_value,
                     rsp_ch.byte_offset, rsp_ch.page_number, rsp_ch.page_checksum};
         if (expected_q.size() == 0) begin
            report_mismatch("transaction with none pending", 16'(got_now.event_res), 16'hx);
         end else begin
            want_now = expected_q.pop_front();
            got_f = fields_of(got_now);
            want_f = fields_of(want_now);
            for (int f = 0; f < 6; f++)
               if (got_f[f] !== want_f[f]) report_mismatch(field_names[f], got_f[f], want_f[f]);
         end
      end
   end

   always @(posedge clock) begin
      rsp_ch.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
   end

   task automatic send_byte(input logic [7:0] b, input bit pin = 1'b0,
                            input loader_rsp_type want = '0);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      pin_q.push_back('{pin, want});
      req_ch.valid <= 1'b1;
      req_ch.rx_byte <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent_count++;
   endtask

   task automatic send_hex(input int digits, input logic [15:0] value);
      for (int i = digits - 1; i >= 0; i--) send_byte(hex_char(value[4 * i +: 4]));
   endtask

   task automatic drain_results;
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == REG_MODE_ADDR) m_update_mode = value[0];
      else m_first_page = value[11:0];
   endtask

   task automatic send_page(input logic [15:0] start);
      send_byte(ASCII_AT);
      send_hex(4, start);
      repeat (WORDS_PER_PAGE) send_hex(4, 16'($urandom_range(16'hFFFF)));
   endtask

   task automatic send_random_upload;
      int sel;
      logic [15:0] data;
      sel = $urandom_range(99);
      data = ($urandom_range(9) == 0) ? {16{sel[0]}} : 16'($urandom_range(16'hFFFF));
      if (sel < 60) begin
         send_byte(ASCII_AT);
         send_hex(4, data);
         repeat ($urandom_range(1, 6)) send_hex(4, 16'($urandom_range(16'hFFFF)));
      end else if (sel < 75) begin
         send_hex($urandom_range(1, 4), data);
      end else if (sel < 85) begin
         send_byte(CMD_BYTES[$urandom_range(3)]);
      end else if (sel < 93) begin
         send_byte(8'($urandom_range(255)));
      end else begin
         send_byte(ASCII_AT);
         send_hex($urandom_range(1, 3), data);
         send_byte(($urandom_range(1) == 0) ? CMD_BYTES[$urandom_range(3)] :
                   8'($urandom_range(255)));
      end
   endtask

   task automatic send_random_normal;
      int sel;
      int n;
      sel = $urandom_range(99);
      if (sel < 35) begin
         for (int k = 0; k < 6; k++) send_byte(KEYWORD[k]);
      end else if (sel < 60) begin
         n = $urandom_range(1, 5);
         for (int k = 0; k < n; k++) send_byte(KEYWORD[k]);
         send_byte(8'($urandom_range(255)));
      end else if (sel < 70) begin
         send_byte(ASCII_U);
      end else begin
         repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
      end
   endtask

   initial begin
      int start;
      logic [11:0] page_base;
      req_ch.valid <= 1'b0;
      req_ch.rx_byte <= 8'h00;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < PLAN_ROWS; i++) begin
         if (plan[i].kind == ROW_CSR) begin
            drain_results();
            write_reg(plan[i].addr, plan[i].data);
         end else begin
            send_byte(plan[i].data[7:0], plan[i].pin, plan[i].want);
         end
      end

      // phase pairs: no idling, sender idle, receiver stall, both; normal then upload mode
      for (int p = 0; p < 8; p++) begin
         drain_results();
         send_idle_pct = (p / 2 == 1 || p / 2 == 3) ? ((p / 2 == 1) ? 69 : 10) : 0;
         stall_pct = (p / 2 == 2 || p / 2 == 3) ? ((p / 2 == 2) ? 69 : 10) : 0;
         page_base = (p == 1) ? 12'd3968 : (p == 7) ? 12'd4095 : (p == 3) ? 12'd0 :
                     12'($urandom_range(3968));
         write_reg(REG_MODE_ADDR, 32'(p % 2));
         write_reg(REG_PAGE_ADDR, 32'(page_base));
         start = sent_count;
         while (sent_count - start < 55) begin
            if (p % 2 == 1) send_random_upload();
            else send_random_normal();
         end
         if (p == 1) send_page(FINAL_ADDR);
         if (p == 7) send_page(16'($urandom_range(16'hFDFF)));
      end

      // hold off the receiver while bytes keep coming
      drain_results();
      send_idle_pct = 0;
      stall_pct = 0;
      write_reg(REG_MODE_ADDR, 32'd1);
      fork
         begin
            hold_off <= 1'b1;
            repeat (400) @(posedge clock);
            hold_off <= 1'b0;
         end
      join_none
      start = sent_count;
      while (sent_count - start < 60) send_random_upload();

      drain_results();
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/core/hfl_pkg.sv
rtl/core/hfl_if.sv
rtl/core/hfl_csr.sv
rtl/core/hfl_keyword.sv
rtl/core/hfl_hex_parser.sv
rtl/core/hex_firmware_loader_receiver.sv
rtl/core/hfl_checker.sv
tb/tb_top.sv
